[rtl/core/rdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared constants, codes and control/status types of the reload timer.
// ----------------------------------------------------------------------------
package rdt_pkg;

	// Field widths
	localparam int CYCLE_BITS = 12;
	localparam int PRESCALE_W = 14;
	localparam int COUNT_W    = 16;
	localparam int ADDR_W     = 8;
	localparam int DATA_W     = 8;
	localparam int ACTION_W   = 2;
	// signed remainder of the prescaler while periods are drained
	localparam int LEFT_W = ((CYCLE_BITS > PRESCALE_W) ? CYCLE_BITS : PRESCALE_W) + 1;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

	// Register byte offsets
	localparam logic [ADDR_W-1:0] ADDR_LOW  = 8'h18;
	localparam logic [ADDR_W-1:0] ADDR_HIGH = 8'h1C;
	localparam logic [ADDR_W-1:0] ADDR_CTL  = 8'h20;

	// Control byte bits
	localparam int CTL_ENABLE_BIT = 0;
	localparam int CTL_STATUS_BIT = 1;
	localparam int CTL_CLEAR_BIT  = 2;
	localparam int CTL_IRQEN_BIT  = 3;
	localparam int CTL_FAST_BIT   = 4;
	localparam logic [DATA_W-1:0] CTL_ONES = 8'hE0;

	// Prescaler periods
	localparam logic [PRESCALE_W-1:0] SLOW_PERIOD = 14'd2000;
	localparam logic [PRESCALE_W-1:0] FAST_PERIOD = 14'd400;
	localparam logic [PRESCALE_W-1:0] FAST_FIRST  = 14'd500;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 16'hFFFF;

	// Controller to datapath
	typedef struct packed {
		logic capture;   // latch request beat
		logic exec;      // apply read/write, start tick
		logic step;      // one prescaler period or final store
		logic load_out;  // load result register
	} rdt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic tick_run;  // captured item is a tick that runs periods
		logic left_le0;  // prescaler remainder at or below zero
	} rdt_sts_t;

endpackage

[rtl/core/rdt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_req_if / rdt_rsp_if
// Valid/ready channels carrying request and result beats of the timer.
// ----------------------------------------------------------------------------
interface rdt_req_if
	import rdt_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [ADDR_W-1:0]     address;
	logic [DATA_W-1:0]     write_data;
	logic [CYCLE_BITS-1:0] elapsed_cycles;

	modport source (output valid, action, address, write_data, elapsed_cycles, input ready);
	modport sink   (input valid, action, address, write_data, elapsed_cycles, output ready);
endinterface

interface rdt_rsp_if
	import rdt_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  read_data;
	logic               irq;
	logic [COUNT_W-1:0] counter_value;

	modport source (output valid, read_data, irq, counter_value, input ready);
	modport sink   (input valid, read_data, irq, counter_value, output ready);
endinterface

[rtl/core/rdt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_ctrl
// Sequencer: takes a beat, executes it, drains prescaler periods one per
// cycle on a tick, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rdt_ctrl
	import rdt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  rdt_sts_t sts,
	output rdt_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOOP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && req_valid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.step     = (state_q == ST_LOOP);
		cmd.load_out = (state_q == ST_DONE) && slot_free;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= sts.tick_run ? ST_LOOP : ST_DONE;
				end
				ST_LOOP: begin
					if (!sts.left_le0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.load_out) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/rdt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_dp
// Timer datapath: request holding register, control/reload/count state,
// prescaler remainder and result register.
// ----------------------------------------------------------------------------
module rdt_dp
	import rdt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  rdt_cmd_t              cmd,
	output rdt_sts_t              sts,
	input  logic [ACTION_W-1:0]   action,
	input  logic [ADDR_W-1:0]     address,
	input  logic [DATA_W-1:0]     write_data,
	input  logic [CYCLE_BITS-1:0] elapsed_cycles,
	output logic [DATA_W-1:0]     read_data,
	output logic                  irq,
	output logic [COUNT_W-1:0]    counter_value
);

	// Held request beat
	logic [ACTION_W-1:0]   action_q;
	logic [ADDR_W-1:0]     address_q;
	logic [DATA_W-1:0]     wdata_q;
	logic [CYCLE_BITS-1:0] cycles_q;

	// Timer state
	logic                  enable_q;
	logic                  irqen_q;
	logic                  fast_q;
	logic [COUNT_W-1:0]    reload_q;
	logic [COUNT_W-1:0]    count_q;
	logic [PRESCALE_W-1:0] prescale_q;
	logic                  zs_q;
	logic                  zss_q;
	logic                  rwait_q;
	logic [LEFT_W-1:0]     left_q;
	logic [DATA_W-1:0]     rd_q;

	// Result register
	logic [DATA_W-1:0]     out_rd_q;
	logic                  out_irq_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic [DATA_W-1:0]     rd_byte;
	logic [COUNT_W-1:0]    cnt_ld;
	logic [COUNT_W-1:0]    cnt_nx;
	logic [PRESCALE_W-1:0] period;
	logic                  new_en;
	logic                  new_ie;
	logic                  new_fast;

	assign sts.tick_run = (action_q == ACT_TICK) && enable_q && (cycles_q != '0);
	assign sts.left_le0 = $signed(left_q) <= $signed(LEFT_W'(0));

	assign period   = fast_q ? FAST_PERIOD : SLOW_PERIOD;
	assign new_en   = wdata_q[CTL_ENABLE_BIT];
	assign new_ie   = wdata_q[CTL_IRQEN_BIT];
	assign new_fast = wdata_q[CTL_FAST_BIT];

	// One counter period: reload on zero or pending reload, then decrement
	assign cnt_ld = ((count_q == '0) || rwait_q) ? reload_q : count_q;
	assign cnt_nx = (cnt_ld != '0) ? cnt_ld - COUNT_W'(1) : cnt_ld;

	// Register read mux
	always_comb begin
		rd_byte = '0;
		if (action_q == ACT_READ) begin
			if (address_q == ADDR_LOW) rd_byte = count_q[7:0];
			else if (address_q == ADDR_HIGH) rd_byte = count_q[15:8];
			else if (address_q == ADDR_CTL) begin
				rd_byte = CTL_ONES;
				rd_byte[CTL_CLEAR_BIT]  = 1'b1;
				rd_byte[CTL_ENABLE_BIT] = enable_q;
				rd_byte[CTL_STATUS_BIT] = zs_q;
				rd_byte[CTL_IRQEN_BIT]  = irqen_q;
				rd_byte[CTL_FAST_BIT]   = fast_q;
			end
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			address_q <= address;
			wdata_q   <= write_data;
			cycles_q  <= elapsed_cycles;
		end
	end

	// Timer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			irqen_q    <= 1'b0;
			fast_q     <= 1'b0;
			reload_q   <= COUNT_RESET;
			count_q    <= COUNT_RESET;
			prescale_q <= SLOW_PERIOD;
			zs_q       <= 1'b0;
			zss_q      <= 1'b0;
			rwait_q    <= 1'b0;
		end else if (cmd.exec && (action_q == ACT_WRITE)) begin
			if (address_q == ADDR_LOW) begin
				reload_q[7:0] <= wdata_q;
				rwait_q       <= 1'b1;
			end else if (address_q == ADDR_HIGH) begin
				reload_q[15:8] <= wdata_q;
				rwait_q        <= 1'b1;
			end else if (address_q == ADDR_CTL) begin
				// clear is suppressed on the latch while running at zero
				if (wdata_q[CTL_CLEAR_BIT]) begin
					if (!(enable_q && (count_q == '0))) zs_q <= 1'b0;
					zss_q <= 1'b0;
				end
				// turning on seeds the prescaler; first fast period is longer
				if (new_en && !enable_q) prescale_q <= new_fast ? FAST_FIRST : SLOW_PERIOD;
				enable_q <= new_en;
				irqen_q  <= new_ie;
				fast_q   <= new_fast;
				if (!new_ie) begin
					zs_q  <= 1'b0;
					zss_q <= 1'b0;
				end
			end
		end else if (cmd.step) begin
			if (sts.left_le0) begin
				count_q <= cnt_nx;
				rwait_q <= 1'b0;
				if ((cnt_nx == '0) || zs_q) begin
					zs_q  <= 1'b1;
					zss_q <= 1'b1;
				end
			end else begin
				prescale_q <= left_q[PRESCALE_W-1:0];
			end
		end
	end

	// Prescaler remainder and read byte
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			left_q <= LEFT_W'(prescale_q) - LEFT_W'(cycles_q);
			rd_q   <= rd_byte;
		end else if (cmd.step && sts.left_le0) begin
			left_q <= left_q + LEFT_W'(period);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_rd_q    <= rd_q;
			out_irq_q   <= zss_q && irqen_q;
			out_count_q <= count_q;
		end
	end

	assign read_data     = out_rd_q;
	assign irq           = out_irq_q;
	assign counter_value = out_count_q;

endmodule

[rtl/core/reload_down_counter_timer_unit.sv]
`timescale 1ns / 1ps
// Sequence: a read, write, no-op or idle tick (disabled or zero cycles) is
//   captured, executed and then loaded into the output register once it is
//   free; a running tick first drains its prescaler periods in the loop, one
//   period per cycle. A new beat is taken only when idle, after the previous
//   result is loaded, even while it still waits in the output register.
// Reset: arst_n clears control and timer state at once; no clearing pass.
// ----------------------------------------------------------------------------
// reload_down_counter_timer_unit
// 16-bit reloadable down-counter timer behind byte registers, fed by tick,
// read and write beats and answering each with one result beat.
// ----------------------------------------------------------------------------
module reload_down_counter_timer_unit
	import rdt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	rdt_req_if.sink   req,
	rdt_rsp_if.source rsp
);

	rdt_cmd_t cmd;
	rdt_sts_t sts;

	// Sequencer
	rdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	rdt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (req.action),
		.address        (req.address),
		.write_data     (req.write_data),
		.elapsed_cycles (req.elapsed_cycles),
		.read_data      (rsp.read_data),
		.irq            (rsp.irq),
		.counter_value  (rsp.counter_value)
	);

	// A taken beat makes the unit busy on the next cycle
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous beat in flight");

	// Result register is only loaded when the slot is free
	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready))
		else $error("result overwritten before it was taken");

	// Period steps and execution never overlap the idle state
	a_step_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.exec) |-> !req.ready)
		else $error("datapath active while accepting requests");

	// A loaded result shows up as valid on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp.valid)
		else $error("loaded result not presented");

endmodule
